// ===== sv/tacp_pkg.sv =====
package tacp_pkg;

  // Run limits and saturation bounds
  localparam logic [15:0] MAX_SAMPLES = 16'hFFFF;
  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [47:0] S48_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] S48_MIN = 48'h8000_0000_0000;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // Queue between front and back, depth is a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Divider: one quotient bit per cycle
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // One classified sample word
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [32:0] s;      // previous y + y
    logic [32:0] d;      // x - previous x
    logic [7:0]  status;
    logic        first;
    logic        last;
  } item_t;

  typedef struct packed {
    logic  empty;
    item_t head;
  } q_out_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num_mag;
    logic [47:0] den_mag;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [63:0] quo;
  } div_rsp_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_XY,
    BK_WSUM,
    BK_DIV
  } back_state_e;

endpackage

// ===== sv/tacp_front.sv =====
module tacp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [31:0]         sample_x_i,
  input  logic [31:0]         sample_y_i,
  input  logic [7:0]          status_bits_i,
  input  logic                last_sample_i,
  input  logic                q_full_i,
  output logic                in_stall_o,
  output logic                push_o,
  output tacp_pkg::item_t     item_o
);

  logic [31:0] prev_x_q, prev_y_q;
  logic        first_q;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.x      = sample_x_i;
    item_o.y      = sample_y_i;
    item_o.s      = {prev_y_q[31], prev_y_q} + {sample_y_i[31], sample_y_i};
    item_o.d      = {sample_x_i[31], sample_x_i} - {prev_x_q[31], prev_x_q};
    item_o.status = status_bits_i;
    item_o.first  = first_q;
    item_o.last   = last_sample_i;
  end

  // previous sample tracking; a last word restarts the run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= 1'b1;
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else if (push_o) begin
      first_q  <= last_sample_i;
      prev_x_q <= sample_x_i;
      prev_y_q <= sample_y_i;
    end
  end

endmodule

// ===== sv/tacp_fifo.sv =====
module tacp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tacp_pkg::item_t     item_i,
  input  logic                pop_i,
  output logic                full_o,
  output tacp_pkg::q_out_t    q_o
);

  tacp_pkg::item_t                mem_q [tacp_pkg::QDEPTH];
  logic [tacp_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [tacp_pkg::QPTR_W:0]      cnt_q;

  assign full_o     = (cnt_q == (tacp_pkg::QPTR_W+1)'(tacp_pkg::QDEPTH));
  assign q_o.empty  = (cnt_q == '0);
  assign q_o.head   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/tacp_div.sv =====
module tacp_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tacp_pkg::div_req_t   req_i,
  output tacp_pkg::div_rsp_t   rsp_o
);

  logic                            busy_q;
  logic [tacp_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [47:0]                     rem_q, den_q;
  logic [63:0]                     quo_q;
  logic [48:0]                     shifted;
  logic [49:0]                     diff;
  logic                            fits;

  // restoring step: shift one dividend bit into the remainder
  always_comb begin
    shifted = {rem_q, quo_q[63]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    fits    = !diff[49];
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quo  = quo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num_mag;
      den_q <= req_i.den_mag;
    end else if (busy_q) begin
      rem_q <= fits ? diff[47:0] : shifted[47:0];
      quo_q <= {quo_q[62:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= tacp_pkg::DIV_CNT_W'(tacp_pkg::DIV_STEPS - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/tacp_back.sv =====
module tacp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 centroid_mode_i,
  input  tacp_pkg::q_out_t     q_i,
  output logic                 pop_o,
  output tacp_pkg::div_req_t   div_req_o,
  input  tacp_pkg::div_rsp_t   div_rsp_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [63:0]          area_o,
  output logic [31:0]          centroid_o,
  output logic [31:0]          peak_value_o,
  output logic [31:0]          peak_position_o,
  output logic [15:0]          sample_count_o,
  output logic [7:0]           run_status_o
);

  tacp_pkg::back_state_e state_q, state_d;
  tacp_pkg::item_t       cur_q;

  logic signed [65:0] prod_q, prod_d;
  logic signed [32:0] mul_a, mul_b;

  logic [63:0] area_q, wsum_q;
  logic [47:0] isum_q;
  logic [31:0] max_val_q, max_pos_q;
  logic [15:0] count_q;
  logic [7:0]  stat_q;
  logic        neg_q, zero_q;

  logic        mul_xy, acc_en, w_en, div_start, emit;

  logic [65:0] p_rnd;
  logic [63:0] term, area_next, w_next, xy, num_s;
  logic [64:0] area_sum, w_sum;
  logic [48:0] i_sum;
  logic [47:0] i_next, isum_mag;
  logic [31:0] cen;
  logic [63:0] quo;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tacp_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    mul_xy    = 1'b0;
    acc_en    = 1'b0;
    w_en      = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    unique case (state_q)
      tacp_pkg::BK_IDLE: begin
        if (!q_i.empty) begin
          pop_o   = 1'b1;
          state_d = tacp_pkg::BK_XY;
        end
      end
      tacp_pkg::BK_XY: begin
        mul_xy  = 1'b1;
        acc_en  = 1'b1;
        state_d = tacp_pkg::BK_WSUM;
      end
      tacp_pkg::BK_WSUM: begin
        w_en = 1'b1;
        if (cur_q.last) begin
          div_start = 1'b1;
          state_d   = tacp_pkg::BK_DIV;
        end else if (!q_i.empty) begin
          pop_o   = 1'b1;
          state_d = tacp_pkg::BK_XY;
        end else begin
          state_d = tacp_pkg::BK_IDLE;
        end
      end
      tacp_pkg::BK_DIV: begin
        if (!div_rsp_i.busy && (!out_valid_o || !out_stall_i)) begin
          emit    = 1'b1;
          state_d = tacp_pkg::BK_IDLE;
        end
      end
      default: state_d = tacp_pkg::BK_IDLE;
    endcase
  end

  // shared multiplier: trapezoid product on pop, x*y in the following cycle
  always_comb begin
    if (mul_xy) begin
      mul_a = $signed({cur_q.x[31], cur_q.x});
      mul_b = $signed({cur_q.y[31], cur_q.y});
    end else begin
      mul_a = $signed(q_i.head.s);
      mul_b = $signed(q_i.head.d);
    end
    prod_d = mul_a * mul_b;
  end

  // accumulate with saturation
  always_comb begin
    p_rnd     = prod_q + {65'd0, prod_q[65]};   // halve toward zero
    term      = p_rnd[64:1];
    area_sum  = {area_q[63], area_q} + {term[63], term};
    area_next = (area_sum[64] != area_sum[63]) ?
                (area_sum[64] ? tacp_pkg::S64_MIN : tacp_pkg::S64_MAX) : area_sum[63:0];
    xy        = prod_q[63:0];
    w_sum     = {wsum_q[63], wsum_q} + {xy[63], xy};
    w_next    = (w_sum[64] != w_sum[63]) ?
                (w_sum[64] ? tacp_pkg::S64_MIN : tacp_pkg::S64_MAX) : w_sum[63:0];
    i_sum     = {isum_q[47], isum_q} + {{17{cur_q.y[31]}}, cur_q.y};
    i_next    = (i_sum[48] != i_sum[47]) ?
                (i_sum[48] ? tacp_pkg::S48_MIN : tacp_pkg::S48_MAX) : i_sum[47:0];
  end

  // divider operands
  always_comb begin
    isum_mag = isum_q[47] ? (48'd0 - isum_q) : isum_q;
    if (!centroid_mode_i) begin
      num_s             = w_next;
      div_req_o.den_mag = isum_mag;
    end else begin
      num_s             = {{16{isum_q[47]}}, isum_q};
      div_req_o.den_mag = {32'd0, count_q};
    end
    div_req_o.num_mag = num_s[63] ? (64'd0 - num_s) : num_s;
    div_req_o.start   = div_start;
  end

  // quotient sign and clamp to 32 bits
  always_comb begin
    quo = div_rsp_i.quo;
    if (zero_q) begin
      cen = '0;
    end else if (neg_q) begin
      cen = ((quo[63:32] != '0) || (quo[31] && (quo[30:0] != '0))) ?
            tacp_pkg::S32_MIN : (32'd0 - quo[31:0]);
    end else begin
      cen = (quo[63:31] != '0) ? tacp_pkg::S32_MAX : quo[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_i.head;
    end
    if (pop_o || mul_xy) begin
      prod_q <= prod_d;
    end
    if (div_start) begin
      neg_q  <= centroid_mode_i ? isum_q[47] : (w_next[63] != isum_q[47]);
      zero_q <= !centroid_mode_i && (isum_q == '0);
    end
    if (emit) begin
      area_o          <= area_q;
      centroid_o      <= cen;
      peak_value_o    <= max_val_q;
      peak_position_o <= max_pos_q;
      sample_count_o  <= count_q;
      run_status_o    <= stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q      <= '0;
      wsum_q      <= '0;
      isum_q      <= '0;
      max_val_q   <= '0;
      max_pos_q   <= '0;
      count_q     <= '0;
      stat_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (emit) begin
        area_q    <= '0;
        wsum_q    <= '0;
        isum_q    <= '0;
        max_val_q <= '0;
        max_pos_q <= '0;
        count_q   <= '0;
        stat_q    <= '0;
      end else begin
        if (acc_en) begin
          if (!cur_q.first) begin
            area_q <= area_next;
          end
          if (cur_q.first || ($signed(cur_q.y) > $signed(max_val_q))) begin
            max_val_q <= cur_q.y;
            max_pos_q <= cur_q.x;
          end
          isum_q <= i_next;
          if (count_q != tacp_pkg::MAX_SAMPLES) begin
            count_q <= count_q + 1'b1;
          end
          stat_q <= stat_q | cur_q.status;
        end
        if (w_en) begin
          wsum_q <= w_next;
        end
      end
    end
  end

endmodule

// ===== sv/trapezoid_area_centroid_peak_accumulator.sv =====
// Trapezoid area, centroid and peak accumulator. Samples (x, y as signed
// Q16.16, a status byte and a last flag) arrive on the input channel; each
// word is taken by a front end that forms y+prev_y and x-prev_x and queues it
// two deep, so up to two words are taken while the back end is busy (the
// input stalls once the queue is full, e.g. during the divide). The back end
// shares one 33x33 multiplier between the trapezoid product and x*y, so each
// sample takes the XY and WSUM states; that multiplier sets the rate. On the
// word marked last the run closes: a radix-2 divider forms the centroid, after
// which the result word is loaded into the output register and the run clears.
// A waiting result does not hold up accumulation of the next run; only the
// next result waits for the output register to drain. Area and sum(x*y) are
// Q32.32 and saturate, the count saturates at 65535. centroid_mode (cfg_wdata_i,
// written with cfg_we_i while idle) picks the intensity-weighted mean x (0, zero
// when sum y is zero) or the mean y (1); it is sampled at run end.
module trapezoid_area_centroid_peak_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sample_x_i,
  input  logic [31:0] sample_y_i,
  input  logic [7:0]  status_bits_i,
  input  logic        last_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] area_o,
  output logic [31:0] centroid_o,
  output logic [31:0] peak_value_o,
  output logic [31:0] peak_position_o,
  output logic [15:0] sample_count_o,
  output logic [7:0]  run_status_o
);

  logic                 mode_q;
  logic                 push, q_full, pop;
  tacp_pkg::item_t      item;
  tacp_pkg::q_out_t     q_out;
  tacp_pkg::div_req_t   div_req;
  tacp_pkg::div_rsp_t   div_rsp;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // front: classify the word against the previous sample
  tacp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .sample_x_i    (sample_x_i),
    .sample_y_i    (sample_y_i),
    .status_bits_i (status_bits_i),
    .last_sample_i (last_sample_i),
    .q_full_i      (q_full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .item_o        (item)
  );

  // decoupling queue
  tacp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .pop_i  (pop),
    .full_o (q_full),
    .q_o    (q_out)
  );

  // back: multiply, accumulate, emit
  tacp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .centroid_mode_i (mode_q),
    .q_i             (q_out),
    .pop_o           (pop),
    .div_req_o       (div_req),
    .div_rsp_i       (div_rsp),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .area_o          (area_o),
    .centroid_o      (centroid_o),
    .peak_value_o    (peak_value_o),
    .peak_position_o (peak_position_o),
    .sample_count_o  (sample_count_o),
    .run_status_o    (run_status_o)
  );

  // centroid divider
  tacp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // back end never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_out.empty)
    else $error("pop from empty queue");

  // divider is only started when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // a result always covers at least one sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_count_o != 16'd0))
    else $error("result with zero sample count");

endmodule

// ===== dv/tb_trapezoid_area_centroid_peak_accumulator.sv =====
module tb_trapezoid_area_centroid_peak_accumulator;

  localparam int CLK_PERIOD = 8;
  // Settling time for the divider to bring out the result after the last word.
  localparam int SETTLE_CYCLES = 100;
  // Cycle budget for the watchdog, well above the longest legal simulation.
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int RANDOM_PER_PHASE = 285;
  localparam int LONG_RUN = 200;
  localparam longint ISUM_HI = longint'($signed(tacp_pkg::S48_MAX));
  localparam longint ISUM_LO = longint'($signed(tacp_pkg::S48_MIN));

  // One expected result word
  typedef struct {
    logic [63:0] area;
    logic [31:0] centroid;
    logic [31:0] peak_value;
    logic [31:0] peak_position;
    logic [15:0] sample_count;
    logic [7:0]  run_status;
  } run_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] sample_x_i = '0;
  logic [31:0] sample_y_i = '0;
  logic [7:0]  status_bits_i = '0;
  logic        last_sample_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] area_o;
  logic [31:0] centroid_o;
  logic [31:0] peak_value_o;
  logic [31:0] peak_position_o;
  logic [15:0] sample_count_o;
  logic [7:0]  run_status_o;

  trapezoid_area_centroid_peak_accumulator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_x_i      (sample_x_i),
    .sample_y_i      (sample_y_i),
    .status_bits_i   (status_bits_i),
    .last_sample_i   (last_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .area_o          (area_o),
    .centroid_o      (centroid_o),
    .peak_value_o    (peak_value_o),
    .peak_position_o (peak_position_o),
    .sample_count_o  (sample_count_o),
    .run_status_o    (run_status_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Idling odds, percent per cycle, set per phase
  int send_idle_pct = 0;
  int out_stall_pct = 0;
  int failures = 0;

  // Results still owed by the block, oldest first
  run_result_t pending_results[$];

  // Run accumulator mirror: what the block should hold after each accepted word
  logic   centroid_mode_q = 1'b0;
  logic   awaiting_first;
  longint prev_x, prev_y;
  longint area_acc, xy_acc, y_acc;
  longint peak_y, peak_x;
  int     sample_cnt;
  logic [7:0] status_acc;

  function automatic void clear_run();
    awaiting_first = 1'b1;
    prev_x = 0;
    prev_y = 0;
    area_acc = 0;
    xy_acc = 0;
    y_acc = 0;
    peak_y = 0;
    peak_x = 0;
    sample_cnt = 0;
    status_acc = '0;
  endfunction

  // 64-bit signed add, clamped at the rails
  function automatic longint sat_add64(longint a, longint b);
    logic signed [64:0] t;
    t = a;
    t = t + b;
    if (t[64] != t[63]) begin
      return t[64] ? longint'(tacp_pkg::S64_MIN) : longint'(tacp_pkg::S64_MAX);
    end
    return t[63:0];
  endfunction

  // Quotient truncated toward zero, clamped to 32-bit signed; den is never 0
  function automatic longint div_trunc_sat(longint num, longint den);
    logic [63:0] nm, dm, q;
    logic        neg;
    neg = (num < 0) != (den < 0);
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    q = nm / dm;
    if (neg) begin
      if (q > {32'h0, tacp_pkg::S32_MIN}) q = {32'h0, tacp_pkg::S32_MIN};
      return -longint'(q);
    end
    if (q > {32'h0, tacp_pkg::S32_MAX}) q = {32'h0, tacp_pkg::S32_MAX};
    return longint'(q);
  endfunction

  // Fold one accepted sample into the run; on the last one, queue the result and clear.
  function automatic void accumulate_sample(logic [31:0] xw, logic [31:0] yw,
                                            logic [7:0] st, logic last);
    longint x, y, s, d, term, cen;
    logic [63:0] ms, md, prod;
    run_result_t r;
    x = $signed(xw);
    y = $signed(yw);
    if (awaiting_first) begin
      // first sample: no area, it is the peak
      awaiting_first = 1'b0;
      peak_y = y;
      peak_x = x;
    end else begin
      s = prev_y + y;
      d = x - prev_x;
      ms = (s < 0) ? -s : s;
      md = (d < 0) ? -d : d;
      prod = ms * md;  // at most 2^64 - 2^32, fits
      term = prod >> 1;
      if ((s < 0) != (d < 0)) term = -term;
      area_acc = sat_add64(area_acc, term);
      // strictly larger only, so ties keep the first position
      if (y > peak_y) begin
        peak_y = y;
        peak_x = x;
      end
    end
    xy_acc = sat_add64(xy_acc, x * y);
    y_acc = y_acc + y;
    if (y_acc > ISUM_HI) y_acc = ISUM_HI;
    if (y_acc < ISUM_LO) y_acc = ISUM_LO;
    prev_x = x;
    prev_y = y;
    if (sample_cnt < tacp_pkg::MAX_SAMPLES) sample_cnt++;
    status_acc |= st;
    if (last) begin
      // mode taken as it stands when the run closes
      if (!centroid_mode_q) cen = (y_acc != 0) ? div_trunc_sat(xy_acc, y_acc) : 0;
      else cen = div_trunc_sat(y_acc, longint'(sample_cnt));
      r.area = area_acc;
      r.centroid = cen[31:0];
      r.peak_value = peak_y[31:0];
      r.peak_position = peak_x[31:0];
      r.sample_count = sample_cnt[15:0];
      r.run_status = status_acc;
      pending_results.push_back(r);
      clear_run();
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] expd, logic [63:0] got);
    if (got !== expd) begin
      $error("%s mismatch: expected %h, actual %h", name, expd, got);
      failures++;
    end
  endfunction

  function automatic void check_result_word();
    run_result_t r;
    if (pending_results.size() == 0) begin
      $error("result word with nothing expected: area %h", area_o);
      failures++;
    end else begin
      r = pending_results.pop_front();
      check_field("area", r.area, area_o);
      check_field("centroid", {32'h0, r.centroid}, {32'h0, centroid_o});
      check_field("peak_value", {32'h0, r.peak_value}, {32'h0, peak_value_o});
      check_field("peak_position", {32'h0, r.peak_position}, {32'h0, peak_position_o});
      check_field("sample_count", {48'h0, r.sample_count}, {48'h0, sample_count_o});
      check_field("run_status", {56'h0, r.run_status}, {56'h0, run_status_o});
    end
  endfunction

  // Output side: sample the handshake as it stood at the edge, then roll the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result_word();
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Offer one word, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_sample(input logic [31:0] x, input logic [31:0] y,
                             input logic [7:0] st, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_x_i <= x;
    sample_y_i <= y;
    status_bits_i <= st;
    last_sample_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    accumulate_sample(x, y, st, last);
  endtask

  // Hold the input quiet until every owed result word has come out.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Mode changes only with the block idle: drained, then the divider given time to finish.
  task automatic write_mode(input logic m);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    centroid_mode_q = m;
  endtask

  // Intensity or position: mostly realistic Q16.16, some rails, some fully random
  function automatic logic [31:0] random_level();
    int pick;
    logic [31:0] v;
    pick = $urandom_range(15);
    case (pick)
      0: v = tacp_pkg::S32_MIN;
      1: v = tacp_pkg::S32_MAX;
      2: v = '0;
      3: v = '1;
      4, 5, 6: v = $urandom();
      default: v = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] random_status();
    int pick;
    pick = $urandom_range(3);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'h01 << $urandom_range(7);
    return 8'($urandom_range(255));
  endfunction

  task automatic test_directed();
    write_mode(1'b0);
    // lone sample: no area, it is its own peak
    send_sample(tacp_pkg::S32_MIN, tacp_pkg::S32_MAX, 8'h01, 1'b1);
    // y cancels to zero, weighted centroid falls back to 0
    send_sample(32'h0001_0000, 32'h0005_0000, 8'h80, 1'b0);
    send_sample(32'h0002_0000, 32'hFFFB_0000, 8'h00, 1'b1);
    // flat top: peak stays with the first x
    send_sample(32'h0001_0000, 32'h0007_0000, 8'h02, 1'b0);
    send_sample(32'h0002_0000, 32'h0007_0000, 8'h00, 1'b0);
    send_sample(32'h0003_0000, 32'h0007_0000, 8'h04, 1'b1);
    // negative first peak, then a rise, then a tie
    send_sample(32'h0000_0005, 32'hFFFF_FFF7, 8'h08, 1'b0);
    send_sample(32'h0000_0006, 32'hFFFF_FFFD, 8'h10, 1'b0);
    send_sample(32'h0000_0007, 32'hFFFF_FFFD, 8'h20, 1'b1);
    // two near-full positive slices: area clamps high
    send_sample(tacp_pkg::S32_MIN, tacp_pkg::S32_MAX, 8'h40, 1'b0);
    send_sample(tacp_pkg::S32_MAX, tacp_pkg::S32_MAX, 8'h00, 1'b0);
    send_sample(tacp_pkg::S32_MAX, tacp_pkg::S32_MIN, 8'h00, 1'b0);
    send_sample(tacp_pkg::S32_MIN, tacp_pkg::S32_MIN, 8'h00, 1'b1);
    // mirror image: area clamps low
    send_sample(tacp_pkg::S32_MAX, tacp_pkg::S32_MAX, 8'h00, 1'b0);
    send_sample(tacp_pkg::S32_MIN, tacp_pkg::S32_MAX, 8'h00, 1'b0);
    send_sample(tacp_pkg::S32_MIN, tacp_pkg::S32_MIN, 8'h00, 1'b0);
    send_sample(tacp_pkg::S32_MAX, tacp_pkg::S32_MIN, 8'hFF, 1'b1);
    // sum(x*y) clamps high over a tiny sum(y): centroid clamps high
    send_sample(tacp_pkg::S32_MIN, tacp_pkg::S32_MIN, 8'h00, 1'b0);
    send_sample(tacp_pkg::S32_MIN, tacp_pkg::S32_MIN, 8'h00, 1'b0);
    send_sample(tacp_pkg::S32_MAX, tacp_pkg::S32_MAX, 8'h00, 1'b0);
    send_sample(tacp_pkg::S32_MAX, tacp_pkg::S32_MAX, 8'h00, 1'b0);
    send_sample(32'h0000_0000, 32'h0000_0003, 8'h00, 1'b1);
    // sum(x*y) clamps low: centroid clamps low
    send_sample(tacp_pkg::S32_MIN, tacp_pkg::S32_MAX, 8'h00, 1'b0);
    send_sample(tacp_pkg::S32_MIN, tacp_pkg::S32_MAX, 8'h00, 1'b0);
    send_sample(tacp_pkg::S32_MAX, tacp_pkg::S32_MIN, 8'h00, 1'b1);
  endtask

  // Mode flips while a run is open; the closing word must use the new mode.
  task automatic test_mode_at_emission();
    write_mode(1'b0);
    send_sample(32'h0001_0000, 32'h0002_0000, 8'h00, 1'b0);
    send_sample(32'h0002_0000, 32'h0006_0000, 8'h00, 1'b0);
    write_mode(1'b1);
    send_sample(32'h0003_0000, 32'h0001_0000, 8'h00, 1'b1);
  endtask

  // One long run of full-scale intensity at full rate, mean-y centroid.
  task automatic test_long_run();
    logic [31:0] x;
    write_mode(1'b1);
    send_idle_pct = 0;
    out_stall_pct = 0;
    x = random_level();
    for (int i = 1; i <= LONG_RUN; i++) begin
      x = x + $urandom_range(1, 16'hFFFF);
      send_sample(x, tacp_pkg::S32_MAX, random_status(), i == LONG_RUN);
    end
  endtask

  // Runs of random length; most sweep x upward like a real scan, the rest jump about.
  // Runs carry over phase boundaries, so mode changes also land mid-run.
  task automatic test_random();
    int left_in_run;
    int pick;
    logic sweep;
    logic [31:0] x;
    left_in_run = 0;
    sweep = 1'b1;
    x = '0;
    for (int p = 0; p < 5; p++) begin
      write_mode(p[0]);
      case (p)
        1: begin send_idle_pct = 81; out_stall_pct = 0; end
        2: begin send_idle_pct = 0; out_stall_pct = 81; end
        3: begin send_idle_pct = 30; out_stall_pct = 30; end
        default: begin send_idle_pct = 0; out_stall_pct = 0; end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        // hold off mid-phase until the block has caught up
        if (i == RANDOM_PER_PHASE / 2) wait_results_drained();
        if (left_in_run == 0) begin
          pick = $urandom_range(9);
          if (pick < 6) left_in_run = $urandom_range(1, 6);
          else if (pick < 9) left_in_run = $urandom_range(7, 40);
          else left_in_run = $urandom_range(41, 150);
          sweep = ($urandom_range(3) != 0);
          x = random_level();
        end
        if (sweep) x = x + $urandom_range(1, 32'h0004_0000);
        else x = random_level();
        left_in_run--;
        send_sample(x, random_level(), random_status(), left_in_run == 0);
      end
    end
  endtask

  initial begin
    clear_run();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_mode_at_emission();
    test_long_run();
    test_random();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
